[rtl/core/rvx_pkg.sv]
// Shared types and constants for the RV32I execute core.
// Opcodes, status codes, pipeline structs. No dependencies.
`default_nettype none
package rvx_pkg;
  localparam int DMEM_BYTES = 4096;
  localparam int DMEM_AW = $clog2(DMEM_BYTES);

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNSUPP  = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  localparam logic [2:0] LD_B  = 3'd0;
  localparam logic [2:0] LD_H  = 3'd1;
  localparam logic [2:0] LD_W  = 3'd2;
  localparam logic [2:0] LD_BU = 3'd4;
  localparam logic [2:0] LD_HU = 3'd5;

  typedef struct packed {
    logic        we;
    logic [3:0]  be;
    logic [31:0] addr;
    logic [31:0] data;
  } dmem_req_t;

  typedef struct packed {
    logic        pending;
    logic [2:0]  f3;
    logic [1:0]  lane0;
  } load_ctl_t;
endpackage
`default_nettype wire

[rtl/core/rvx_dmem.sv]
// Byte-wide little-endian data memory, four banks, registered read.
// Depends on rvx_pkg.
`default_nettype none
module rvx_dmem
  import rvx_pkg::*;
(
  input  wire logic        clk,
  input  wire dmem_req_t   req,
  input  wire logic        re,
  output logic [31:0]      rdata
);
  logic [1:0]         lane [4];
  logic [DMEM_AW-1:0] ba [4];
  logic [7:0]         wb [4];
  logic               wen [4];

  // Bank j holds the bytes whose address ends in j; rdata comes back in bank order.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      lane[j] = 2'(j) - req.addr[1:0];
      ba[j] = DMEM_AW'((req.addr + 32'(lane[j])) % 32'(DMEM_BYTES));
      wb[j] = req.data[8*lane[j] +: 8];
      wen[j] = req.we && req.be[lane[j]];
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0] bank [DMEM_BYTES/4];
    logic [7:0] q;

    always_ff @(posedge clk) begin
      if (wen[j]) bank[ba[j][DMEM_AW-1:2]] <= wb[j];
      if (re) q <= bank[ba[j][DMEM_AW-1:2]];
    end

    assign rdata[8*j +: 8] = q;
  end
endmodule
`default_nettype wire

[rtl/core/rvx_regfile.sv]
// 32 x 32 register file, synchronous read, without write forwarding.
// Depends on rvx_pkg; valid bits give the all-zero reset.
`default_nettype none
module rvx_regfile
  import rvx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        re,
  input  wire logic [4:0]  ra1,
  input  wire logic [4:0]  ra2,
  input  wire logic        we,
  input  wire logic [4:0]  wa,
  input  wire logic [31:0] wd,
  output logic [31:0]      rd1,
  output logic [31:0]      rd2
);
  logic [31:0] mem [32];
  logic [31:0] vld;
  logic [31:0] m1, m2;
  logic        v1, v2;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) begin
      m1 <= mem[ra1];
      m2 <= mem[ra2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (we) vld[wa] <= 1'b1;
      if (re) begin
        v1 <= vld[ra1] && ra1 != 5'd0;
        v2 <= vld[ra2] && ra2 != 5'd0;
      end
    end
  end

  assign rd1 = v1 ? m1 : '0;
  assign rd2 = v2 ? m2 : '0;
endmodule
`default_nettype wire

[rtl/core/rv32i_instruction_execute_core.sv]
// RV32I execute core: one instruction word in, one result word out.
// Register read at accept, execute in stage 1, result registered to the outputs;
// a load also passes through the data-memory read register and ld_v.
// Throughput one word per cycle while the output is not stalled; a load holds
// back the next word, and back-to-back dependent words use register forwarding.
// Synchronous reset clears registers and the pc to zero.
// Depends on rvx_pkg, rvx_regfile, rvx_dmem.
`default_nettype none
module rv32i_instruction_execute_core
  import rvx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] instr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      pc_after,
  output logic             reg_written,
  output logic [4:0]       reg_index,
  output logic [31:0]      reg_value,
  output logic             stored,
  output logic [31:0]      store_address,
  output logic [1:0]       status
);
  logic        s1_v;
  logic [31:0] s1_ins;
  logic [31:0] pc;
  logic        ld_v;
  logic [31:0] ld_pc;
  logic [4:0]  ld_rd;
  load_ctl_t   ld_ctl;
  logic        fw_v;
  logic [4:0]  fw_rd;
  logic [31:0] fw_val;
  logic [31:0] rf1, rf2, a, b, dm_rd;
  logic        adv, ex_fire, wb_we;
  logic [4:0]  wb_wa;
  logic [31:0] wb_wd;
  dmem_req_t   dreq;

  logic [6:0]  op;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, a_imm;
  logic [31:0] nxt, val;
  logic [1:0]  stt;
  logic        wr, st, ld, tk;
  logic [31:0] opb, lraw, lval;
  logic [4:0]  sh;

  assign cfg_ready = !s1_v && !ld_v && !out_valid;
  // stage 1 holds when a load is completing or output stalled
  assign adv = !out_valid || out_ready;
  assign ex_fire = s1_v && adv && !ld_v;
  assign in_ready = (!s1_v || ex_fire) && !(s1_v && ld) ;

  rvx_regfile u_rf (
    .clk(clk), .rst(rst), .re(in_valid && in_ready),
    .ra1(instr[19:15]), .ra2(instr[24:20]),
    .we(wb_we), .wa(wb_wa), .wd(wb_wd), .rd1(rf1), .rd2(rf2));

  always_comb begin
    rs1 = s1_ins[19:15];
    rs2 = s1_ins[24:20];
    a = (fw_v && fw_rd == rs1 && rs1 != 5'd0) ? fw_val : rf1;
    b = (fw_v && fw_rd == rs2 && rs2 != 5'd0) ? fw_val : rf2;
  end

  always_comb begin
    op = s1_ins[6:0];
    rd = s1_ins[11:7];
    f3 = s1_ins[14:12];
    f7 = s1_ins[31:25];
    imm_i = {{20{s1_ins[31]}}, s1_ins[31:20]};
    imm_s = {{20{s1_ins[31]}}, s1_ins[31:25], s1_ins[11:7]};
    imm_b = {{19{s1_ins[31]}}, s1_ins[31], s1_ins[7], s1_ins[30:25], s1_ins[11:8], 1'b0};
    imm_u = {s1_ins[31:12], 12'd0};
    imm_j = {{11{s1_ins[31]}}, s1_ins[31], s1_ins[19:12], s1_ins[20], s1_ins[30:21], 1'b0};
    a_imm = a + imm_i;
    nxt = pc + 32'd4;
    val = '0;
    stt = ST_OK;
    wr = 1'b0;
    st = 1'b0;
    ld = 1'b0;
    tk = 1'b0;
    opb = (op == OP_REG) ? b : imm_i;
    sh = opb[4:0];
    unique case (op)
      OP_LUI: begin wr = 1'b1; val = imm_u; end
      OP_AUIPC: begin wr = 1'b1; val = pc + imm_u; end
      OP_JAL: begin wr = 1'b1; val = pc + 32'd4; nxt = pc + imm_j; end
      OP_JALR: begin
        if (f3 != 3'd0) stt = ST_ILLEGAL;
        else begin wr = 1'b1; val = pc + 32'd4; nxt = {a_imm[31:1], 1'b0}; end
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: tk = a == b;
          3'd1: tk = a != b;
          3'd4: tk = $signed(a) < $signed(b);
          3'd5: tk = !($signed(a) < $signed(b));
          3'd6: tk = a < b;
          3'd7: tk = a >= b;
          default: stt = ST_ILLEGAL;
        endcase
        if (tk) nxt = pc + imm_b;
      end
      OP_LOAD: begin
        if (f3 inside {LD_B, LD_H, LD_W, LD_BU, LD_HU}) begin wr = 1'b1; ld = 1'b1; end
        else stt = ST_ILLEGAL;
      end
      OP_STORE: begin
        if (f3 > 3'd2) stt = ST_ILLEGAL;
        else st = 1'b1;
      end
      OP_IMM, OP_REG: begin
        wr = 1'b1;
        if (op == OP_REG && !(f7 == 7'd0 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))))
          stt = ST_ILLEGAL;
        else if (op == OP_IMM && f3 == 3'd1 && f7 != 7'd0) stt = ST_ILLEGAL;
        else if (op == OP_IMM && f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20) stt = ST_ILLEGAL;
        case (f3)
          3'd0: val = (op == OP_REG && f7 == 7'h20) ? a - b : a + opb;
          3'd1: val = a << sh;
          3'd2: val = {31'd0, $signed(a) < $signed(opb)};
          3'd3: val = {31'd0, a < opb};
          3'd4: val = a ^ opb;
          3'd5: val = (f7 == 7'h20) ? 32'($signed(a) >>> sh) : a >> sh;
          3'd6: val = a | opb;
          default: val = a & opb;
        endcase
      end
      OP_SYSTEM: stt = (f3 == 3'd4) ? ST_ILLEGAL : ST_UNSUPP;
      default: stt = ST_ILLEGAL;
    endcase
    if (stt != ST_OK) begin
      wr = 1'b0; st = 1'b0; ld = 1'b0; nxt = pc;
    end
    if (rd == 5'd0) wr = 1'b0;
  end

  always_comb begin
    dreq.addr = st ? a + imm_s : a_imm;
    dreq.data = b;
    dreq.we = ex_fire && st;
    case (f3[1:0])
      2'd0: dreq.be = 4'b0001;
      2'd1: dreq.be = 4'b0011;
      default: dreq.be = 4'b1111;
    endcase
  end

  rvx_dmem u_dm (.clk(clk), .req(dreq), .re(ex_fire && ld), .rdata(dm_rd));

  always_comb begin
    lraw = 32'({dm_rd, dm_rd} >> {ld_ctl.lane0, 3'b000});
    case (ld_ctl.f3)
      LD_B: lval = {{24{lraw[7]}}, lraw[7:0]};
      LD_H: lval = {{16{lraw[15]}}, lraw[15:0]};
      LD_BU: lval = {24'd0, lraw[7:0]};
      LD_HU: lval = {16'd0, lraw[15:0]};
      default: lval = lraw;
    endcase
  end

  always_comb begin
    wb_we = 1'b0;
    wb_wa = rd;
    wb_wd = val;
    if (ld_v) begin
      wb_we = 1'b1; wb_wa = ld_rd; wb_wd = lval;
    end else if (ex_fire && wr && !ld) begin
      wb_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      ld_v <= 1'b0;
      fw_v <= 1'b0;
      out_valid <= 1'b0;
      pc <= '0;
      ld_ctl.pending <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) pc <= cfg_data;
      out_valid <= ld_v || (ex_fire && !(ld && rd != 5'd0)) || (out_valid && !out_ready);
      if (in_valid && in_ready) begin
        s1_v <= 1'b1;
        s1_ins <= instr;
      end else if (ex_fire) begin
        s1_v <= 1'b0;
      end
      if (wb_we) begin
        fw_v <= 1'b1;
        fw_rd <= wb_wa;
        fw_val <= wb_wd;
      end
      ld_v <= ex_fire && ld && rd != 5'd0;
      ld_ctl.pending <= ex_fire && ld;
      if (ld_v) begin
        pc_after <= ld_pc;
        reg_written <= 1'b1;
        reg_index <= ld_rd;
        reg_value <= lval;
        stored <= 1'b0;
        store_address <= '0;
        status <= ST_OK;
      end else if (ex_fire) begin
        pc <= nxt;
        if (ld) begin
          ld_ctl.f3 <= f3;
          ld_ctl.lane0 <= dreq.addr[1:0];
          ld_pc <= nxt;
          ld_rd <= rd;
        end
        pc_after <= nxt;
        reg_written <= wr;
        reg_index <= wr ? rd : 5'd0;
        reg_value <= wr ? val : 32'd0;
        stored <= st;
        store_address <= st ? dreq.addr : 32'd0;
        status <= stt;
      end
    end
  end

  a_ld_one: assert property (@(posedge clk) disable iff (rst) ld_v |=> !ld_v)
    else $error("load completion lasted two cycles");
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> !s1_v && !out_valid)
    else $error("config write while busy");
  a_st_ld: assert property (@(posedge clk) disable iff (rst) out_valid |-> !(stored && reg_written))
    else $error("store reported a register write");
endmodule
`default_nettype wire
